### rtl/fcc_pkg.sv
// Package for the frame checksum checker.
// Holds the parser phase type, framing characters and command codes.
// No dependencies.
package fcc_pkg;

  // Framing characters
  localparam logic [7:0] CH_START    = 8'h23; // '#'
  localparam logic [7:0] CH_LEN_OPEN = 8'h28; // '('
  localparam logic [7:0] CH_LEN_CLS  = 8'h29; // ')'
  localparam logic [7:0] CH_END      = 8'h5E; // '^'
  localparam logic [7:0] CH_ERROR    = 8'h2A; // '*'
  localparam logic [7:0] CH_QUERY    = 8'h3F; // '?'
  localparam logic [7:0] CH_PLUS     = 8'h2B; // '+'
  localparam logic [7:0] CH_BANG     = 8'h21; // '!'
  localparam logic [7:0] CH_AT       = 8'h40; // '@'
  localparam logic [7:0] CH_TILDE    = 8'h7E; // '~'
  localparam logic [7:0] CH_ZERO     = 8'h30; // '0'
  localparam logic [7:0] CH_NINE     = 8'h39; // '9'

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned SUM_W    = 24;
  localparam int unsigned RSUM_W   = 30;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned TARGET_W = 4;

  // Limits
  localparam logic [TARGET_W-1:0] DIGITS_CAP      = 4'd9;
  localparam logic [COUNT_W-1:0]  MAX_PAYLOAD_RST = 16'd1000;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PLUS    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_BANG    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_AT      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TILDE   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 3'd5;

  // Parser phase
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_CMD,
    PH_PAYLOAD,
    PH_LEN,
    PH_DIGITS
  } phase_t;

  // Map a command character to its code
  function automatic logic [CMD_W-1:0] command_code(input logic [BYTE_W-1:0] c);
    logic [CMD_W-1:0] code;
    unique case (c)
      CH_QUERY: code = CMD_QUERY;
      CH_PLUS:  code = CMD_PLUS;
      CH_BANG:  code = CMD_BANG;
      CH_AT:    code = CMD_AT;
      CH_TILDE: code = CMD_TILDE;
      default:  code = CMD_UNKNOWN;
    endcase
    return code;
  endfunction

endpackage

### rtl/frame_checksum_checker.sv
// Frame checksum checker top level: per-word frame parser and result register.
// Depends on fcc_pkg.
//
// Usage:
//   The input channel (in_valid/in_ready/in_rx_byte) takes one received
//   character per word. Frames look like '#', command, payload, '(', length
//   digits, ')', checksum digits, '^'. A '^' word produces one result word on
//   the output channel (out_valid/out_ready and the out_ fields); every other
//   word only updates the parser state and produces nothing.
//   Throughput: one input word per cycle. The parser state update for a word
//   is a single register stage (saturating add, one multiply-by-ten add).
//   Latency: the result for a '^' word is valid in the cycle after its accept.
//   Stall: the result register holds while out_ready is low. Input words are
//   accepted whenever no result waits or the waiting one is taken in the same
//   cycle, so in_ready drops for every word while a result waits and the
//   receiver is stalled.
//   Reset (rst_n low, synchronous): parser returns to hunting for '#', all
//   frame state clears, no result is pending and max_payload returns to 1000.
//   Configuration: cfg_we writes cfg_wdata into max_payload; write only idle.
module frame_checksum_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [fcc_pkg::BYTE_W-1:0]   in_rx_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [fcc_pkg::CMD_W-1:0]    out_command,
  output logic                         out_checksum_ok,
  output logic                         out_frame_error,
  output logic [fcc_pkg::SUM_W-1:0]    out_computed_sum,
  output logic [fcc_pkg::RSUM_W-1:0]   out_received_sum,
  input  logic                         cfg_we,
  input  logic [fcc_pkg::COUNT_W-1:0]  cfg_wdata
);
  import fcc_pkg::*;

  // State registers
  phase_t                phase_r, phase_nxt;
  logic [SUM_W-1:0]      byte_sum_r, byte_sum_nxt;
  logic [BYTE_W-1:0]     cmd_char_r, cmd_char_nxt;
  logic [TARGET_W-1:0]   target_r, target_nxt;
  logic [TARGET_W-1:0]   taken_r, taken_nxt;
  logic [RSUM_W-1:0]     parsed_r, parsed_nxt;
  logic [COUNT_W-1:0]    count_r, count_nxt;
  logic                  early_err_r, early_err_nxt;
  logic [COUNT_W-1:0]    max_payload_r;

  // Result register
  logic                  out_valid_r;
  logic [CMD_W-1:0]      out_cmd_r;
  logic                  out_ok_r;
  logic                  out_err_r;
  logic [SUM_W-1:0]      out_csum_r;
  logic [RSUM_W-1:0]     out_rsum_r;

  logic                  accept;
  logic                  is_end;
  logic                  is_digit;
  logic [BYTE_W-1:0]     digit_val;
  logic [SUM_W:0]        sum_wide;
  logic [TARGET_W:0]     target_wide;
  logic [CMD_W-1:0]      code;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign is_end    = (in_rx_byte == CH_END);
  assign is_digit  = (in_rx_byte >= CH_ZERO) && (in_rx_byte <= CH_NINE);
  assign digit_val = in_rx_byte - CH_ZERO;
  assign sum_wide  = {1'b0, byte_sum_r} + {{(SUM_W+1-BYTE_W){1'b0}}, in_rx_byte};
  assign target_wide = {1'b0, target_r} + {1'b0, digit_val[TARGET_W-1:0]};
  assign code      = command_code(cmd_char_r);

  // Next frame state for the word at the input
  always_comb begin
    phase_nxt     = phase_r;
    byte_sum_nxt  = byte_sum_r;
    cmd_char_nxt  = cmd_char_r;
    target_nxt    = target_r;
    taken_nxt     = taken_r;
    parsed_nxt    = parsed_r;
    count_nxt     = count_r;
    early_err_nxt = early_err_r;
    if (is_end) begin
      phase_nxt     = PH_HUNT;
      byte_sum_nxt  = '0;
      cmd_char_nxt  = '0;
      target_nxt    = '0;
      taken_nxt     = '0;
      parsed_nxt    = '0;
      count_nxt     = '0;
      early_err_nxt = 1'b0;
    end else begin
      unique case (phase_r)
        PH_HUNT: begin
          if (in_rx_byte == CH_START) begin
            phase_nxt = PH_CMD;
          end else if (in_rx_byte == CH_ERROR) begin
            early_err_nxt = 1'b1;
          end
        end
        PH_CMD: begin
          cmd_char_nxt = in_rx_byte;
          phase_nxt    = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (in_rx_byte == CH_LEN_OPEN) begin
            phase_nxt = PH_LEN;
          end else begin
            // saturate sum and count
            byte_sum_nxt = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
            if (count_r != '1) begin
              count_nxt = count_r + 1'b1;
            end
          end
        end
        PH_LEN: begin
          if (in_rx_byte == CH_LEN_CLS) begin
            phase_nxt = PH_DIGITS;
          end else if (is_digit) begin
            target_nxt = target_wide[TARGET_W] ? '1 : target_wide[TARGET_W-1:0];
          end
        end
        PH_DIGITS: begin
          if (is_digit && (taken_r < target_r) && (taken_r < DIGITS_CAP)) begin
            parsed_nxt = (parsed_r << 3) + (parsed_r << 1)
                       + {{(RSUM_W-BYTE_W){1'b0}}, digit_val};
            taken_nxt  = taken_r + 1'b1;
          end
        end
        default: begin
          phase_nxt     = PH_HUNT;
          byte_sum_nxt  = '0;
          cmd_char_nxt  = '0;
          target_nxt    = '0;
          taken_nxt     = '0;
          parsed_nxt    = '0;
          count_nxt     = '0;
          early_err_nxt = 1'b0;
        end
      endcase
    end
  end

  // Advance frame state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      byte_sum_r  <= '0;
      cmd_char_r  <= '0;
      target_r    <= '0;
      taken_r     <= '0;
      parsed_r    <= '0;
      count_r     <= '0;
      early_err_r <= 1'b0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      byte_sum_r  <= byte_sum_nxt;
      cmd_char_r  <= cmd_char_nxt;
      target_r    <= target_nxt;
      taken_r     <= taken_nxt;
      parsed_r    <= parsed_nxt;
      count_r     <= count_nxt;
      early_err_r <= early_err_nxt;
    end
  end

  // Hold the payload limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      max_payload_r <= cfg_wdata;
    end
  end

  // Result valid: set on an accepted end word, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && is_end) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Capture the result payload
  always_ff @(posedge clk) begin
    if (accept && is_end) begin
      out_cmd_r  <= code;
      out_ok_r   <= (parsed_r == {{(RSUM_W-SUM_W){1'b0}}, byte_sum_r});
      out_err_r  <= early_err_r || (count_r > max_payload_r) || (code == CMD_UNKNOWN);
      out_csum_r <= byte_sum_r;
      out_rsum_r <= parsed_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_command      = out_cmd_r;
  assign out_checksum_ok  = out_ok_r;
  assign out_frame_error  = out_err_r;
  assign out_computed_sum = out_csum_r;
  assign out_received_sum = out_rsum_r;

endmodule

### rtl/fcc_checker.sv
// Port-level checker for the frame checksum checker, with its bind.
// Depends on fcc_pkg and frame_checksum_checker.
module fcc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [fcc_pkg::BYTE_W-1:0]   in_rx_byte,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [fcc_pkg::CMD_W-1:0]    out_command,
  input logic                         out_checksum_ok,
  input logic                         out_frame_error,
  input logic [fcc_pkg::SUM_W-1:0]    out_computed_sum,
  input logic [fcc_pkg::RSUM_W-1:0]   out_received_sum
);
  import fcc_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_received_sum)
      && $stable(out_computed_sum) && $stable(out_command))
    else $error("stalled result changed");

  // A new result only follows an accepted end word
  a_rise_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && (in_rx_byte == CH_END)))
    else $error("result without end word");

  // Input is never blocked while no result waits
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with no pending result");

  // Checksum flag agrees with the two sums
  a_ok_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_checksum_ok ==
      (out_received_sum == {{(RSUM_W-SUM_W){1'b0}}, out_computed_sum})))
    else $error("checksum flag disagrees with sums");

  // Unknown command always flags an error
  a_unknown_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_command == CMD_UNKNOWN) |-> out_frame_error)
    else $error("unknown command without frame error");

endmodule

bind frame_checksum_checker fcc_checker u_fcc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_rx_byte       (in_rx_byte),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_command      (out_command),
  .out_checksum_ok  (out_checksum_ok),
  .out_frame_error  (out_frame_error),
  .out_computed_sum (out_computed_sum),
  .out_received_sum (out_received_sum)
);
